// ===== rtl/bfe_pkg.sv =====
// shared types, constants and codes of the body fat estimator
package bfe_pkg;

    // stream and field widths
    localparam int unsigned WEIGHT_W  = 15;
    localparam int unsigned IMP_W     = 16;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned FAT_W     = 10;
    localparam int unsigned HEIGHT_W  = 8;
    localparam int unsigned AGE_W     = 8;
    localparam int unsigned OFFSET_W  = 9;
    localparam int unsigned S_DATA_W  = 80;
    localparam int unsigned S_USER_W  = 3;
    localparam int unsigned M_DATA_W  = 32;
    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned CFG_DATA_W = 9;

    // datapath widths
    localparam int unsigned ACC_W  = 36;
    localparam int unsigned MULA_W = 23;
    localparam int unsigned MULB_W = 18;
    localparam int unsigned PROD_W = MULA_W + MULB_W;
    localparam int unsigned D_W    = 22;
    localparam int unsigned HH_W   = 16;

    // record expiry window in ms
    localparam logic [TIME_W-1:0] EXPIRY_MS = 32'd30000;

    // register reset values
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 8'd170;
    localparam logic [AGE_W-1:0]    AGE_RST    = 8'd30;
    localparam logic [OFFSET_W-1:0] OFFSET_RST = 9'd0;

    // lean mass coefficients, units of 1e-7 kg
    localparam logic signed [MULA_W-1:0] K_HEIGHT = 23'sd9058;
    localparam logic signed [MULA_W-1:0] K_WEIGHT = 23'sd32000;
    localparam logic signed [MULA_W-1:0] K_IMP    = 23'sd6800;
    localparam logic signed [MULA_W-1:0] K_AGE    = 23'sd542000;
    localparam logic signed [MULA_W-1:0] K_CAP    = 23'sd98000;
    localparam logic signed [MULA_W-1:0] K_DEN    = 23'sd100;
    localparam logic signed [MULA_W-1:0] K_FULL   = 23'sd100000;
    localparam logic signed [ACC_W-1:0]  LEAN_BASE = 36'sd122260000;

    // clamp limits in tenths of a percent
    localparam logic [FAT_W-1:0]         FAT_MIN   = 10'd50;
    localparam logic [FAT_W-1:0]         FAT_MAX   = 10'd750;
    localparam logic signed [MULB_W-1:0] FAT_MIN_S = 18'sd50;
    localparam logic signed [MULB_W-1:0] FAT_MAX_S = 18'sd750;

    // divider length, one quotient bit per cycle
    localparam logic [3:0] DIV_LAST = 4'd9;

    // configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_HEIGHT = 2'd0,
        REG_AGE    = 2'd1,
        REG_OFFSET = 2'd2
    } reg_idx_t;

    // top level control states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_WAIT
    } top_state_t;

    // arithmetic unit states
    typedef enum logic [2:0] {
        CS_IDLE,
        CS_MUL,
        CS_ACC,
        CS_DIV,
        CS_DONE
    } calc_state_t;

    // micro-operations of the shared multiplier
    typedef enum logic [3:0] {
        OP_HH,
        OP_HH9,
        OP_W32,
        OP_I68,
        OP_A542,
        OP_CAP,
        OP_D,
        OP_T0,
        OP_OFF,
        OP_LO,
        OP_HI
    } op_t;

    // user settings seen by the arithmetic unit
    typedef struct packed {
        logic [HEIGHT_W-1:0] height;
        logic [AGE_W-1:0]    age;
        logic [OFFSET_W-1:0] offset;
    } cfg_t;

    // request to the arithmetic unit
    typedef struct packed {
        logic                start;
        logic [WEIGHT_W-1:0] weight;
        logic [IMP_W-1:0]    imp;
    } calc_req_t;

    // status from the arithmetic unit
    typedef struct packed {
        logic             done;
        logic [FAT_W-1:0] fat;
    } calc_rsp_t;

endpackage

// ===== rtl/body_fat_estimator_core.sv =====
// top level: report gathering, settings, result register and the arithmetic unit
//
// Each input beat is one scale report; weight and the two impedances are gathered
// in a pending record that expires once more than 30000 ms have passed since its
// last update. A report that completes the record starts the estimate; the core
// then drops s_tready until the result is handed to the output register. The
// estimate runs on one shared multiplier in 11 steps, each a multiply state and an
// accumulate state, followed by a restoring divider and a done state. When the
// lower clamp settles the result the divider and the last step are skipped, the
// upper clamp skips the divider, and a zero weight skips every step and the
// divider. A report that does not complete the record leaves s_tready high. One
// result may wait in the output register while the next reports are taken; a
// second finished estimate holds s_tready low until that result is taken.
// Settings are written through cfg_we/cfg_addr.
module body_fat_estimator_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    // input reports
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // weight[14:0], low_imp[30:15], high_imp[46:31], time_ms[78:47]
    input  logic [bfe_pkg::S_DATA_W-1:0]      s_tdata,
    // weight_present[0], low_present[1], high_present[2]
    input  logic [bfe_pkg::S_USER_W-1:0]      s_tuser,
    // results
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // weight_out[14:0], fat_tenths[24:15]
    output logic [bfe_pkg::M_DATA_W-1:0]      m_tdata,
    // settings
    input  logic                              cfg_we,
    input  logic [bfe_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [bfe_pkg::CFG_DATA_W-1:0]    cfg_data
);

    bfe_pkg::top_state_t state_reg, state_next;

    logic [bfe_pkg::HEIGHT_W-1:0] height_reg;
    logic [bfe_pkg::AGE_W-1:0]    age_reg;
    logic [bfe_pkg::OFFSET_W-1:0] offset_reg;

    logic                         active_reg, active_next;
    logic [bfe_pkg::TIME_W-1:0]   last_reg, last_next;
    logic                         have_w_reg, have_w_next;
    logic [bfe_pkg::WEIGHT_W-1:0] w_reg, w_next;
    logic                         have_lo_reg, have_lo_next;
    logic [bfe_pkg::IMP_W-1:0]    lo_reg, lo_next;
    logic                         have_hi_reg, have_hi_next;
    logic [bfe_pkg::IMP_W-1:0]    hi_reg, hi_next;

    logic                         m_tvalid_reg, m_tvalid_next;
    logic [bfe_pkg::WEIGHT_W-1:0] out_w_reg, out_w_next;
    logic [bfe_pkg::FAT_W-1:0]    out_fat_reg, out_fat_next;
    logic [bfe_pkg::WEIGHT_W-1:0] calc_w_reg, calc_w_next;

    logic [bfe_pkg::WEIGHT_W-1:0] in_w;
    logic [bfe_pkg::IMP_W-1:0]    in_lo;
    logic [bfe_pkg::IMP_W-1:0]    in_hi;
    logic [bfe_pkg::TIME_W-1:0]   in_time;
    logic [bfe_pkg::TIME_W-1:0]   elapsed;
    logic                         expired;
    logic                         in_accept;
    logic                         complete;
    logic                         out_free;
    logic                         load_out;

    logic                         upd_have_w, upd_have_lo, upd_have_hi;
    logic [bfe_pkg::WEIGHT_W-1:0] upd_w;
    logic [bfe_pkg::IMP_W-1:0]    upd_lo, upd_hi;

    bfe_pkg::cfg_t      calc_cfg;
    bfe_pkg::calc_req_t calc_req;
    bfe_pkg::calc_rsp_t calc_rsp;

    // unpack the input beat
    assign in_w    = s_tdata[14:0];
    assign in_lo   = s_tdata[30:15];
    assign in_hi   = s_tdata[46:31];
    assign in_time = s_tdata[78:47];

    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    // record update: expire first, then overwrite with present values
    assign elapsed = in_time - last_reg;
    assign expired = !active_reg || (elapsed > bfe_pkg::EXPIRY_MS);

    always_comb
    begin
        upd_have_w  = expired ? 1'b0 : have_w_reg;
        upd_w       = expired ? '0 : w_reg;
        upd_have_lo = expired ? 1'b0 : have_lo_reg;
        upd_lo      = expired ? '0 : lo_reg;
        upd_have_hi = expired ? 1'b0 : have_hi_reg;
        upd_hi      = expired ? '0 : hi_reg;
        if (s_tuser[0])
        begin
            upd_have_w = 1'b1;
            upd_w      = in_w;
        end
        if (s_tuser[1])
        begin
            upd_have_lo = 1'b1;
            upd_lo      = in_lo;
        end
        if (s_tuser[2])
        begin
            upd_have_hi = 1'b1;
            upd_hi      = in_hi;
        end
    end

    assign complete = upd_have_w && upd_have_lo && upd_have_hi;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bfe_pkg::ST_IDLE:
            begin
                if (in_accept && complete)
                begin
                    state_next = bfe_pkg::ST_CALC;
                end
            end
            bfe_pkg::ST_CALC:
            begin
                if (calc_rsp.done)
                begin
                    state_next = out_free ? bfe_pkg::ST_IDLE : bfe_pkg::ST_WAIT;
                end
            end
            bfe_pkg::ST_WAIT:
            begin
                if (out_free)
                begin
                    state_next = bfe_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bfe_pkg::ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        s_tready = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            bfe_pkg::ST_IDLE: s_tready = 1'b1;
            bfe_pkg::ST_CALC: load_out = calc_rsp.done && out_free;
            bfe_pkg::ST_WAIT: load_out = out_free;
            default:
            begin
                s_tready = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    // pending record and output register next values
    always_comb
    begin
        active_next   = active_reg;
        last_next     = last_reg;
        have_w_next   = have_w_reg;
        w_next        = w_reg;
        have_lo_next  = have_lo_reg;
        lo_next       = lo_reg;
        have_hi_next  = have_hi_reg;
        hi_next       = hi_reg;
        calc_w_next   = calc_w_reg;
        out_w_next    = out_w_reg;
        out_fat_next  = out_fat_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        if (in_accept)
        begin
            if (complete)
            begin
                // record goes back to reset once it yields a result
                active_next  = 1'b0;
                last_next    = '0;
                have_w_next  = 1'b0;
                w_next       = '0;
                have_lo_next = 1'b0;
                lo_next      = '0;
                have_hi_next = 1'b0;
                hi_next      = '0;
                calc_w_next  = upd_w;
            end
            else
            begin
                active_next  = 1'b1;
                last_next    = in_time;
                have_w_next  = upd_have_w;
                w_next       = upd_w;
                have_lo_next = upd_have_lo;
                lo_next      = upd_lo;
                have_hi_next = upd_have_hi;
                hi_next      = upd_hi;
            end
        end
        if (load_out)
        begin
            m_tvalid_next = 1'b1;
            out_w_next    = calc_w_reg;
            out_fat_next  = calc_rsp.fat;
        end
    end

    // settings registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg <= bfe_pkg::HEIGHT_RST;
            age_reg    <= bfe_pkg::AGE_RST;
            offset_reg <= bfe_pkg::OFFSET_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                bfe_pkg::REG_HEIGHT: height_reg <= cfg_data[bfe_pkg::HEIGHT_W-1:0];
                bfe_pkg::REG_AGE:    age_reg    <= cfg_data[bfe_pkg::AGE_W-1:0];
                bfe_pkg::REG_OFFSET: offset_reg <= cfg_data;
                default:             height_reg <= height_reg;
            endcase
        end
    end

    // control and record registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= bfe_pkg::ST_IDLE;
            active_reg   <= 1'b0;
            last_reg     <= '0;
            have_w_reg   <= 1'b0;
            w_reg        <= '0;
            have_lo_reg  <= 1'b0;
            lo_reg       <= '0;
            have_hi_reg  <= 1'b0;
            hi_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            active_reg   <= active_next;
            last_reg     <= last_next;
            have_w_reg   <= have_w_next;
            w_reg        <= w_next;
            have_lo_reg  <= have_lo_next;
            lo_reg       <= lo_next;
            have_hi_reg  <= have_hi_next;
            hi_reg       <= hi_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        calc_w_reg  <= calc_w_next;
        out_w_reg   <= out_w_next;
        out_fat_reg <= out_fat_next;
    end

    // arithmetic unit
    assign calc_cfg.height = height_reg;
    assign calc_cfg.age    = age_reg;
    assign calc_cfg.offset = offset_reg;
    assign calc_req.start  = in_accept && complete;
    assign calc_req.weight = upd_w;
    assign calc_req.imp    = (upd_lo > upd_hi) ? upd_lo : upd_hi;

    bfe_calc u_calc
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (calc_cfg),
        .req   (calc_req),
        .rsp   (calc_rsp)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, out_fat_reg, out_w_reg};

endmodule

// ===== rtl/bfe_calc.sv =====
// sequenced fat estimate: one shared multiplier, accumulator and restoring divider
module bfe_calc
(
    input  logic             clk,
    input  logic             rst_n,
    input  bfe_pkg::cfg_t     cfg,
    input  bfe_pkg::calc_req_t req,
    output bfe_pkg::calc_rsp_t rsp
);

    bfe_pkg::calc_state_t state_reg, state_next;
    bfe_pkg::op_t         op_reg, op_next;
    logic [3:0]           cnt_reg, cnt_next;

    logic [bfe_pkg::WEIGHT_W-1:0] w_reg, w_next;
    logic [bfe_pkg::IMP_W-1:0]    imp_reg, imp_next;
    logic [bfe_pkg::HH_W-1:0]     hh_reg, hh_next;
    logic [bfe_pkg::D_W-1:0]      d_reg, d_next;
    logic signed [bfe_pkg::ACC_W-1:0] prod_reg, prod_next;
    logic signed [bfe_pkg::ACC_W-1:0] lean_reg, lean_next;
    logic signed [bfe_pkg::ACC_W-1:0] t_reg, t_next;
    logic [bfe_pkg::ACC_W-1:0]    rem_reg, rem_next;
    logic [bfe_pkg::ACC_W-1:0]    div_reg, div_next;
    logic [bfe_pkg::FAT_W-1:0]    quo_reg, quo_next;
    logic [bfe_pkg::FAT_W-1:0]    fat_reg, fat_next;

    logic signed [bfe_pkg::MULA_W-1:0] mul_a;
    logic signed [bfe_pkg::MULB_W-1:0] mul_b;
    logic signed [bfe_pkg::PROD_W-1:0] mul_p;

    logic lean_gt;
    logic t_le;
    logic t_ge;
    logic div_ge;

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (op_reg)
            bfe_pkg::OP_HH:
            begin
                mul_a = $signed({15'd0, cfg.height});
                mul_b = $signed({10'd0, cfg.height});
            end
            bfe_pkg::OP_HH9:
            begin
                mul_a = bfe_pkg::K_HEIGHT;
                mul_b = $signed({2'd0, hh_reg});
            end
            bfe_pkg::OP_W32:
            begin
                mul_a = bfe_pkg::K_WEIGHT;
                mul_b = $signed({3'd0, w_reg});
            end
            bfe_pkg::OP_I68:
            begin
                mul_a = bfe_pkg::K_IMP;
                mul_b = $signed({2'd0, imp_reg});
            end
            bfe_pkg::OP_A542:
            begin
                mul_a = bfe_pkg::K_AGE;
                mul_b = $signed({10'd0, cfg.age});
            end
            bfe_pkg::OP_CAP:
            begin
                mul_a = bfe_pkg::K_CAP;
                mul_b = $signed({3'd0, w_reg});
            end
            bfe_pkg::OP_D:
            begin
                mul_a = bfe_pkg::K_DEN;
                mul_b = $signed({3'd0, w_reg});
            end
            bfe_pkg::OP_T0:
            begin
                mul_a = bfe_pkg::K_FULL;
                mul_b = $signed({3'd0, w_reg});
            end
            bfe_pkg::OP_OFF:
            begin
                mul_a = $signed({1'b0, d_reg});
                mul_b = $signed({{9{cfg.offset[8]}}, cfg.offset});
            end
            bfe_pkg::OP_LO:
            begin
                mul_a = $signed({1'b0, d_reg});
                mul_b = bfe_pkg::FAT_MIN_S;
            end
            bfe_pkg::OP_HI:
            begin
                mul_a = $signed({1'b0, d_reg});
                mul_b = bfe_pkg::FAT_MAX_S;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // compares against the registered product and the divider step
    assign lean_gt = lean_reg > prod_reg;
    assign t_le    = t_reg <= prod_reg;
    assign t_ge    = t_reg >= prod_reg;
    assign div_ge  = rem_reg >= div_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bfe_pkg::CS_IDLE:
            begin
                if (req.start)
                begin
                    state_next = (req.weight == '0) ? bfe_pkg::CS_DONE : bfe_pkg::CS_MUL;
                end
            end
            bfe_pkg::CS_MUL:
            begin
                state_next = bfe_pkg::CS_ACC;
            end
            bfe_pkg::CS_ACC:
            begin
                if (op_reg == bfe_pkg::OP_LO && t_le)
                begin
                    state_next = bfe_pkg::CS_DONE;
                end
                else if (op_reg == bfe_pkg::OP_HI)
                begin
                    state_next = t_ge ? bfe_pkg::CS_DONE : bfe_pkg::CS_DIV;
                end
                else
                begin
                    state_next = bfe_pkg::CS_MUL;
                end
            end
            bfe_pkg::CS_DIV:
            begin
                if (cnt_reg == bfe_pkg::DIV_LAST)
                begin
                    state_next = bfe_pkg::CS_DONE;
                end
            end
            bfe_pkg::CS_DONE:
            begin
                state_next = bfe_pkg::CS_IDLE;
            end
            default:
            begin
                state_next = bfe_pkg::CS_IDLE;
            end
        endcase
    end

    // datapath actions per state and micro-operation
    always_comb
    begin
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        w_next    = w_reg;
        imp_next  = imp_reg;
        hh_next   = hh_reg;
        d_next    = d_reg;
        prod_next = prod_reg;
        lean_next = lean_reg;
        t_next    = t_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        quo_next  = quo_reg;
        fat_next  = fat_reg;
        case (state_reg)
            bfe_pkg::CS_IDLE:
            begin
                if (req.start)
                begin
                    w_next   = req.weight;
                    imp_next = req.imp;
                    op_next  = bfe_pkg::OP_HH;
                    // zero weight has no defined ratio, report the upper clamp
                    fat_next = bfe_pkg::FAT_MAX;
                end
            end
            bfe_pkg::CS_MUL:
            begin
                prod_next = mul_p[bfe_pkg::ACC_W-1:0];
            end
            bfe_pkg::CS_ACC:
            begin
                op_next = bfe_pkg::op_t'(op_reg + 4'd1);
                case (op_reg)
                    bfe_pkg::OP_HH:   hh_next   = prod_reg[bfe_pkg::HH_W-1:0];
                    bfe_pkg::OP_HH9:  lean_next = prod_reg + bfe_pkg::LEAN_BASE;
                    bfe_pkg::OP_W32:  lean_next = lean_reg + prod_reg;
                    bfe_pkg::OP_I68:  lean_next = lean_reg - prod_reg;
                    bfe_pkg::OP_A542: lean_next = lean_reg - prod_reg;
                    bfe_pkg::OP_CAP:  lean_next = lean_gt ? prod_reg : lean_reg;
                    bfe_pkg::OP_D:    d_next    = prod_reg[bfe_pkg::D_W-1:0];
                    bfe_pkg::OP_T0:   t_next    = prod_reg - lean_reg;
                    bfe_pkg::OP_OFF:  t_next    = t_reg + prod_reg;
                    bfe_pkg::OP_LO:
                    begin
                        if (t_le)
                        begin
                            fat_next = bfe_pkg::FAT_MIN;
                        end
                    end
                    bfe_pkg::OP_HI:
                    begin
                        // rounding numerator 2T+D over divisor 2D, top quotient bit first
                        fat_next = bfe_pkg::FAT_MAX;
                        rem_next = {t_reg[bfe_pkg::ACC_W-2:0], 1'b0} + {14'd0, d_reg};
                        div_next = {4'd0, d_reg, 10'd0};
                        quo_next = '0;
                        cnt_next = '0;
                    end
                    default:
                    begin
                        lean_next = lean_reg;
                    end
                endcase
            end
            bfe_pkg::CS_DIV:
            begin
                if (div_ge)
                begin
                    rem_next = rem_reg - div_reg;
                end
                div_next = {1'b0, div_reg[bfe_pkg::ACC_W-1:1]};
                quo_next = {quo_reg[bfe_pkg::FAT_W-2:0], div_ge};
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == bfe_pkg::DIV_LAST)
                begin
                    fat_next = {quo_reg[bfe_pkg::FAT_W-2:0], div_ge};
                end
            end
            default:
            begin
                fat_next = fat_reg;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bfe_pkg::CS_IDLE;
            op_reg    <= bfe_pkg::OP_HH;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            cnt_reg   <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        w_reg    <= w_next;
        imp_reg  <= imp_next;
        hh_reg   <= hh_next;
        d_reg    <= d_next;
        prod_reg <= prod_next;
        lean_reg <= lean_next;
        t_reg    <= t_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        quo_reg  <= quo_next;
        fat_reg  <= fat_next;
    end

    assign rsp.done = (state_reg == bfe_pkg::CS_DONE);
    assign rsp.fat  = fat_reg;

endmodule

// ===== dv/testbench.sv =====
// self-checking testbench for the body fat estimator core
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 60;
    localparam int RANDOM_PER_PHASE = 64;

    // one decoded scale report as the sender sees it
    typedef struct packed {
        logic                         wp;
        logic [bfe_pkg::WEIGHT_W-1:0] weight;
        logic                         lp;
        logic [bfe_pkg::IMP_W-1:0]    imp_lo;
        logic                         hp;
        logic [bfe_pkg::IMP_W-1:0]    imp_hi;
        logic [bfe_pkg::TIME_W-1:0]   ms;
    } scale_report_t;

    // one finished estimate
    typedef struct packed {
        logic [bfe_pkg::WEIGHT_W-1:0] weight;
        logic [bfe_pkg::FAT_W-1:0]    fat;
    } fat_result_t;

    logic                           clk      = 1'b0;
    logic                           rst_n    = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [bfe_pkg::S_DATA_W-1:0]   s_tdata  = '0;
    logic [bfe_pkg::S_USER_W-1:0]   s_tuser  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [bfe_pkg::M_DATA_W-1:0]   m_tdata;
    logic                           cfg_we   = 1'b0;
    logic [bfe_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [bfe_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // stimulus and scoreboard
    scale_report_t report_queue[$];
    fat_result_t   expected_fat[$];
    scale_report_t next_report;
    fat_result_t   seen_fat;
    fat_result_t   predicted_fat;
    fat_result_t   oldest_fat;
    logic          s_took = 1'b0;
    bit            idle_on = 1'b1;
    int            send_gap = 0;
    int            recv_gap = 0;
    int            stall_cycles = 0;
    int            mismatches = 0;
    int            queued_reports = 0;
    int            reports_taken = 0;
    int            estimates_seen = 0;
    int            settings_used = 0;
    logic [bfe_pkg::TIME_W-1:0] gen_ms = '0;

    // predictor copy of the settings
    logic [bfe_pkg::HEIGHT_W-1:0]        cfg_height = bfe_pkg::HEIGHT_RST;
    logic [bfe_pkg::AGE_W-1:0]           cfg_age    = bfe_pkg::AGE_RST;
    logic signed [bfe_pkg::OFFSET_W-1:0] cfg_offset = bfe_pkg::OFFSET_RST;

    // predictor copy of the pending record
    logic                         rec_active = 1'b0;
    logic [bfe_pkg::TIME_W-1:0]   rec_last   = '0;
    logic                         rec_has_w  = 1'b0;
    logic [bfe_pkg::WEIGHT_W-1:0] rec_weight = '0;
    logic                         rec_has_lo = 1'b0;
    logic [bfe_pkg::IMP_W-1:0]    rec_imp_lo = '0;
    logic                         rec_has_hi = 1'b0;
    logic [bfe_pkg::IMP_W-1:0]    rec_imp_hi = '0;

    body_fat_estimator_core i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    always #1 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // fat percent in tenths from weight and the larger impedance
    function automatic logic [bfe_pkg::FAT_W-1:0] fat_estimate(
        input logic [bfe_pkg::WEIGHT_W-1:0] w,
        input logic [bfe_pkg::IMP_W-1:0] imp);
        longint h;
        longint lean;
        longint cap;
        longint d;
        longint t;
        h    = longint'(cfg_height);
        lean = h * h * 9058 + longint'(w) * 32000 + 64'sd122260000
               - longint'(imp) * 6800 - longint'(cfg_age) * 542000;
        cap  = longint'(w) * 98000;
        if (w == '0)
            return bfe_pkg::FAT_MAX;
        if (lean > cap)
            lean = cap;
        d = longint'(w) * 100;
        t = (longint'(w) * 100000 - lean) + longint'(cfg_offset) * d;
        if (t <= longint'(bfe_pkg::FAT_MIN) * d)
            return bfe_pkg::FAT_MIN;
        if (t >= longint'(bfe_pkg::FAT_MAX) * d)
            return bfe_pkg::FAT_MAX;
        return bfe_pkg::FAT_W'((2 * t + d) / (2 * d));
    endfunction

    function automatic void drop_record();
        rec_active = 1'b0;
        rec_last   = '0;
        rec_has_w  = 1'b0;
        rec_weight = '0;
        rec_has_lo = 1'b0;
        rec_imp_lo = '0;
        rec_has_hi = 1'b0;
        rec_imp_hi = '0;
    endfunction

    // fold one accepted report into the record, returns 1 when an estimate is due
    function automatic bit take_report(input logic [bfe_pkg::S_DATA_W-1:0] d,
                                       input logic [bfe_pkg::S_USER_W-1:0] u,
                                       output fat_result_t res);
        logic [bfe_pkg::TIME_W-1:0] now;
        logic [bfe_pkg::IMP_W-1:0]  imp;
        now = d[78:47];
        res = '0;
        if (!rec_active || bfe_pkg::TIME_W'(now - rec_last) > bfe_pkg::EXPIRY_MS)
            drop_record();
        rec_active = 1'b1;
        rec_last   = now;
        if (u[0])
        begin
            rec_has_w  = 1'b1;
            rec_weight = d[14:0];
        end
        if (u[1])
        begin
            rec_has_lo = 1'b1;
            rec_imp_lo = d[30:15];
        end
        if (u[2])
        begin
            rec_has_hi = 1'b1;
            rec_imp_hi = d[46:31];
        end
        if (!(rec_has_w && rec_has_lo && rec_has_hi))
            return 1'b0;
        imp = (rec_imp_lo > rec_imp_hi) ? rec_imp_lo : rec_imp_hi;
        res.weight = rec_weight;
        res.fat    = fat_estimate(rec_weight, imp);
        drop_record();
        return 1'b1;
    endfunction

    // input beats: next report or a random gap, changed at the falling edge
    always @(negedge clk)
    begin
        if (!s_tvalid || s_took)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                s_tvalid <= 1'b0;
            end
            else if (report_queue.size() > 0)
            begin
                next_report = report_queue.pop_front();
                s_tdata  <= {1'b0, next_report.ms, next_report.imp_hi,
                             next_report.imp_lo, next_report.weight};
                s_tuser  <= {next_report.hp, next_report.lp, next_report.wp};
                s_tvalid <= 1'b1;
                if (idle_on && $urandom_range(0, 4) == 0)
                    send_gap = $urandom_range(1, 19);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // result side backpressure in bursts
    always @(negedge clk)
    begin
        if (recv_gap > 0)
        begin
            recv_gap--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            if (idle_on && $urandom_range(0, 6) == 0)
                recv_gap = $urandom_range(1, 19);
        end
    end

    // monitor: check result beats, predict from report beats, watchdog
    always @(posedge clk)
    begin
        s_took <= s_tvalid && (s_tready === 1'b1);
        if (m_tvalid === 1'b1 && m_tready)
        begin
            seen_fat.weight = m_tdata[14:0];
            seen_fat.fat    = m_tdata[24:15];
            estimates_seen++;
            if (expected_fat.size() == 0)
                report_mismatch($sformatf("result beat with none expected: weight %0d fat %0d",
                                          seen_fat.weight, seen_fat.fat));
            else
            begin
                oldest_fat = expected_fat.pop_front();
                if (seen_fat.weight !== oldest_fat.weight)
                    report_mismatch($sformatf("weight_out got %0d want %0d",
                                              seen_fat.weight, oldest_fat.weight));
                if (seen_fat.fat !== oldest_fat.fat)
                    report_mismatch($sformatf("fat_tenths got %0d want %0d (weight %0d)",
                                              seen_fat.fat, oldest_fat.fat, oldest_fat.weight));
            end
        end
        if (s_tvalid && s_tready === 1'b1)
        begin
            reports_taken++;
            if (take_report(s_tdata, s_tuser, predicted_fat))
                expected_fat.push_back(predicted_fat);
        end
        if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic push_report(input int wp, input int w, input int lp, input int lo,
                               input int hp, input int hi,
                               input logic [bfe_pkg::TIME_W-1:0] ms);
        scale_report_t r;
        r.wp     = wp[0];
        r.weight = w[bfe_pkg::WEIGHT_W-1:0];
        r.lp     = lp[0];
        r.imp_lo = lo[bfe_pkg::IMP_W-1:0];
        r.hp     = hp[0];
        r.imp_hi = hi[bfe_pkg::IMP_W-1:0];
        r.ms     = ms;
        report_queue.push_back(r);
        queued_reports++;
    endtask

    // random contents, nothing marked present
    function automatic scale_report_t random_report();
        scale_report_t r;
        case ($urandom_range(0, 3))
            0: r.weight = bfe_pkg::WEIGHT_W'($urandom());
            1: r.weight = $urandom_range(0, 1) ? '1 : '0;
            default: r.weight = bfe_pkg::WEIGHT_W'($urandom_range(2000, 15000));
        endcase
        r.imp_lo = $urandom_range(0, 2) == 0 ? bfe_pkg::IMP_W'($urandom())
                                             : bfe_pkg::IMP_W'($urandom_range(3000, 9000));
        r.imp_hi = $urandom_range(0, 2) == 0 ? bfe_pkg::IMP_W'($urandom())
                                             : bfe_pkg::IMP_W'($urandom_range(3000, 9000));
        r.wp = 1'b0;
        r.lp = 1'b0;
        r.hp = 1'b0;
        r.ms = '0;
        return r;
    endfunction

    // one measurement: mostly complete sequences, some broken ones and noise
    task automatic queue_measurement();
        int kind;
        int n;
        int slot_w;
        int slot_lo;
        int slot_hi;
        logic [2:0] bits;
        scale_report_t r;
        kind = $urandom_range(0, 19);
        if (kind < 14)
        begin
            n = $urandom_range(1, 3);
            slot_w  = $urandom_range(0, n - 1);
            slot_lo = $urandom_range(0, n - 1);
            slot_hi = $urandom_range(0, n - 1);
            for (int k = 0; k < n; k++)
            begin
                r = random_report();
                r.wp = (k == slot_w)  || ($urandom_range(0, 5) == 0);
                r.lp = (k == slot_lo) || ($urandom_range(0, 5) == 0);
                r.hp = (k == slot_hi) || ($urandom_range(0, 5) == 0);
                if ($urandom_range(0, 3) == 0)
                    gen_ms += $urandom_range(25000, 30000);
                else
                    gen_ms += $urandom_range(0, 2000);
                r.ms = gen_ms;
                push_report(int'(r.wp), int'(r.weight), int'(r.lp), int'(r.imp_lo),
                            int'(r.hp), int'(r.imp_hi), r.ms);
            end
        end
        else if (kind < 17)
        begin
            // reports that each leave out a field, then expiry, time going back or a jump
            n = $urandom_range(1, 2);
            for (int k = 0; k < n; k++)
            begin
                r = random_report();
                bits = 3'($urandom_range(1, 6));
                gen_ms += $urandom_range(0, 2000);
                push_report(int'(bits[0]), int'(r.weight), int'(bits[1]), int'(r.imp_lo),
                            int'(bits[2]), int'(r.imp_hi), gen_ms);
            end
            case ($urandom_range(0, 2))
                0: gen_ms += $urandom_range(30001, 100000);
                1: gen_ms -= $urandom_range(1, 5000);
                default: gen_ms = $urandom();
            endcase
        end
        else
        begin
            r = random_report();
            bits = 3'($urandom_range(0, 7));
            if ($urandom_range(0, 1) == 0)
                gen_ms = $urandom();
            else
                gen_ms += $urandom_range(0, 40000);
            push_report(int'(bits[0]), int'(r.weight), int'(bits[1]), int'(r.imp_lo),
                        int'(bits[2]), int'(r.imp_hi), gen_ms);
        end
    endtask

    task automatic write_setting(input bfe_pkg::reg_idx_t idx,
                                 input logic [bfe_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        case (idx)
            bfe_pkg::REG_HEIGHT: cfg_height = val[bfe_pkg::HEIGHT_W-1:0];
            bfe_pkg::REG_AGE:    cfg_age    = val[bfe_pkg::AGE_W-1:0];
            bfe_pkg::REG_OFFSET: cfg_offset = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // sender holds off until every estimate is back and the core has settled
    task automatic wait_drained();
        while (report_queue.size() != 0 || s_tvalid || expected_fat.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input int h, input int a, input int o);
        int start;
        write_setting(bfe_pkg::REG_HEIGHT, h[bfe_pkg::CFG_DATA_W-1:0]);
        write_setting(bfe_pkg::REG_AGE, a[bfe_pkg::CFG_DATA_W-1:0]);
        write_setting(bfe_pkg::REG_OFFSET, o[bfe_pkg::CFG_DATA_W-1:0]);
        settings_used++;
        start = queued_reports;
        while (queued_reports - start < RANDOM_PER_PHASE)
            queue_measurement();
        wait_drained();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        settings_used = 1;

        // directed reports under reset settings
        push_report(0, 0, 0, 0, 0, 0, 1000);
        push_report(1, 0, 1, 5000, 1, 5200, 1100);
        push_report(1, 32767, 1, 0, 1, 0, 1200);
        push_report(1, 30000, 1, 65535, 1, 65535, 1300);
        // values gathered over three reports, low impedance larger
        push_report(1, 7500, 0, 0, 0, 0, 1400);
        push_report(0, 0, 1, 6000, 0, 0, 1500);
        push_report(0, 0, 0, 0, 1, 5000, 1600);
        // later weight overwrites the held one, high impedance larger
        push_report(1, 6000, 0, 0, 0, 0, 2000);
        push_report(1, 8200, 0, 0, 1, 4800, 2100);
        push_report(0, 0, 1, 4500, 0, 0, 2200);
        // record expires one ms past the window
        push_report(1, 7000, 0, 0, 0, 0, 3000);
        push_report(0, 0, 1, 5000, 0, 0, 33001);
        push_report(1, 7000, 0, 0, 1, 5000, 33100);
        // exactly at the window still counts
        push_report(1, 9000, 0, 0, 0, 0, 40000);
        push_report(0, 0, 1, 5500, 1, 5600, 70000);
        // time going backwards clears the record
        push_report(1, 8000, 0, 0, 0, 0, 80000);
        push_report(0, 0, 1, 5000, 1, 5000, 79999);
        push_report(1, 8000, 0, 0, 0, 0, 80010);
        // time wrapping through zero keeps the record
        push_report(1, 6500, 0, 0, 0, 0, 32'hFFFF_FFF0);
        push_report(0, 0, 1, 5100, 0, 0, 32'h0000_0010);
        push_report(0, 0, 0, 0, 1, 5300, 32'h0000_0020);
        // empty report refreshes the record time
        push_report(1, 7200, 0, 0, 0, 0, 100000);
        push_report(0, 0, 0, 0, 0, 0, 120000);
        push_report(0, 0, 1, 4000, 1, 4100, 140000);
        // every field at its top value
        push_report(1, 32767, 1, 65535, 1, 65535, 32'hFFFF_FFFF);
        wait_drained();

        // random measurements across settings, extremes first
        gen_ms = 200000;
        run_phase(250, 0, -200);
        run_phase(50, 150, 200);
        run_phase(255, 255, 255);
        run_phase(0, 0, -256);
        run_phase($urandom_range(50, 250), $urandom_range(0, 150), $urandom_range(0, 400) - 200);
        run_phase($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 511) - 256);
        idle_on = 1'b0;
        run_phase(170, 30, 0);

        $display("covered %0d reports, %0d estimates, %0d register settings", reports_taken,
                 estimates_seen, settings_used);
        $display("including expiry, time wrap and rollback, empty and repeated reports, clamps");
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/bfe_pkg.sv
rtl/bfe_calc.sv
rtl/body_fat_estimator_core.sv
dv/testbench.sv
